// ===== hw/rtl/display_digit_frame_formatter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DISPLAY_DIGIT_FRAME_FORMATTER_DEFINES_SVH
`define DISPLAY_DIGIT_FRAME_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDFF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddff assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddff assertion failed");

`endif

// ===== hw/rtl/ddff_pkg.sv =====
package ddff_pkg;

    localparam int BIN_W = 16;
    localparam int CNT_W = 4;
    localparam int ELEM_COUNT = 4;

    localparam logic [1:0] CMD_NUMBER = 2'd0;
    localparam logic [1:0] CMD_CHARS  = 2'd1;
    localparam logic [1:0] CMD_RAW    = 2'd2;
    localparam logic [1:0] CMD_BLANK  = 2'd3;

    localparam logic [3:0] CODE_MINUS = 4'hA;
    localparam logic [3:0] CODE_E     = 4'hB;
    localparam logic [3:0] CODE_H     = 4'hC;
    localparam logic [3:0] CODE_L     = 4'hD;
    localparam logic [3:0] CODE_P     = 4'hE;
    localparam logic [3:0] CODE_BLANK = 4'hF;

    localparam logic [2:0] ADDR_BASE = 3'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] number;
        logic [2:0]  char_count;
        logic [7:0]  elem_a;
        logic [7:0]  elem_b;
        logic [7:0]  elem_c;
        logic [7:0]  elem_d;
    } in_word_t;

    typedef struct packed {
        logic [2:0] frame_address;
        logic [3:0] frame_data;
        logic       last_frame;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } ctrl_cmd_t;

    function automatic logic [3:0] char_to_code(input logic [7:0] c);
        logic [3:0] code;
        code = CODE_BLANK;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            code = c[3:0];
        end
        else
        begin
            unique case (c)
                8'h2D:        code = CODE_MINUS;
                8'h45, 8'h65: code = CODE_E;
                8'h48, 8'h68: code = CODE_H;
                8'h4C, 8'h6C: code = CODE_L;
                8'h50, 8'h70: code = CODE_P;
                default:      code = CODE_BLANK;
            endcase
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/ddff_ctrl.sv =====
module ddff_ctrl #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic                                             is_number,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output ddff_pkg::ctrl_cmd_t                              cmd,
    output logic [((NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1)-1:0] frame_idx
);

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [ddff_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = is_number ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ddff_pkg::CNT_W'(ddff_pkg::BIN_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == IW'(NUM_DIGITS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign frame_idx = idx_reg;

endmodule

// ===== hw/rtl/ddff_datapath.sv =====
module ddff_datapath #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                                             clk,
    input  ddff_pkg::in_word_t                               in_data,
    input  ddff_pkg::ctrl_cmd_t                              cmd,
    input  logic [((NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1)-1:0] frame_idx,
    output logic                                             is_number,
    output ddff_pkg::out_word_t                              out_data
);

    localparam int IW  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int DW  = 4 * NUM_DIGITS;
    localparam int LIM = (NUM_DIGITS < ddff_pkg::ELEM_COUNT) ? NUM_DIGITS
                                                             : ddff_pkg::ELEM_COUNT;

    logic [DW-1:0]                 digits_reg, digits_next;
    logic [ddff_pkg::BIN_W-1:0]    bin_reg, bin_next;
    logic                          num_mode_reg, num_mode_next;
    logic                          ovf_reg, ovf_next;
    logic                          seen_reg, seen_next;
    ddff_pkg::out_word_t           out_reg, out_next;

    logic [7:0]    elems [ddff_pkg::ELEM_COUNT];
    logic [2:0]    cnt_sat;
    logic [DW-1:0] load_codes;
    logic [DW-1:0] adj;
    logic [3:0]    top_digit;
    logic          is_last;
    logic          blank_lead;

    assign elems[0] = in_data.elem_a;
    assign elems[1] = in_data.elem_b;
    assign elems[2] = in_data.elem_c;
    assign elems[3] = in_data.elem_d;

    assign is_number = (in_data.cmd == ddff_pkg::CMD_NUMBER);
    assign cnt_sat   = (in_data.char_count > 3'(LIM)) ? 3'(LIM) : in_data.char_count;

    // Position zero is the leftmost digit and sits in the top nibble.
    always_comb
    begin
        int         e;
        logic [7:0] b;
        logic [3:0] code;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            e    = i + int'(cnt_sat) - NUM_DIGITS;
            b    = elems[e[1:0]];
            code = ddff_pkg::CODE_BLANK;
            unique case (in_data.cmd)
                ddff_pkg::CMD_NUMBER: code = 4'h0;
                ddff_pkg::CMD_CHARS:  code = (e >= 0) ? ddff_pkg::char_to_code(b)
                                                      : ddff_pkg::CODE_BLANK;
                ddff_pkg::CMD_RAW:    code = (e >= 0) ? b[3:0] : ddff_pkg::CODE_BLANK;
                ddff_pkg::CMD_BLANK:  code = ddff_pkg::CODE_BLANK;
                default:              code = ddff_pkg::CODE_BLANK;
            endcase
            load_codes[DW-1-4*i -: 4] = code;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            adj[4*k +: 4] = (digits_reg[4*k +: 4] >= 4'd5) ? digits_reg[4*k +: 4] + 4'd3
                                                           : digits_reg[4*k +: 4];
        end
    end

    assign top_digit  = digits_reg[DW-1 -: 4];
    assign is_last    = (frame_idx == IW'(NUM_DIGITS - 1));
    assign blank_lead = num_mode_reg && !ovf_reg && !seen_reg && (top_digit == 4'h0)
                        && !is_last;

    always_comb
    begin
        digits_next   = digits_reg;
        bin_next      = bin_reg;
        num_mode_next = num_mode_reg;
        ovf_next      = ovf_reg;
        seen_next     = seen_reg;
        out_next      = out_reg;
        if (cmd.load)
        begin
            digits_next   = load_codes;
            bin_next      = in_data.number;
            num_mode_next = is_number;
            ovf_next      = 1'b0;
            seen_next     = 1'b0;
        end
        else if (cmd.shift)
        begin
            // A bit leaving the top digit means the value exceeds the display width.
            digits_next = {adj[DW-2:0], bin_reg[ddff_pkg::BIN_W-1]};
            bin_next    = bin_reg << 1;
            ovf_next    = ovf_reg | adj[DW-1];
        end
        else if (cmd.emit)
        begin
            out_next.frame_address = 3'(frame_idx) + ddff_pkg::ADDR_BASE;
            out_next.frame_data    = blank_lead ? ddff_pkg::CODE_BLANK : top_digit;
            out_next.last_frame    = is_last;
            seen_next              = seen_reg | (top_digit != 4'h0);
            digits_next            = digits_reg << 4;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        bin_reg      <= bin_next;
        num_mode_reg <= num_mode_next;
        ovf_reg      <= ovf_next;
        seen_reg     <= seen_next;
        out_reg      <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/display_digit_frame_formatter.sv =====
// Number requests are accepted and then converted by shift-add-3, one input bit per cycle.
// The frames follow the conversion, one frame per cycle while the sink is ready.
// A number request passes through accept, conversion and emission of NUM_DIGITS frames;
// the other commands skip the conversion. A new request is taken only once idle again.
// rst_n is asynchronous and active low; it idles the controller and empties the output.
module display_digit_frame_formatter #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ddff_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ddff_pkg::out_word_t out_data
);

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    ddff_pkg::ctrl_cmd_t cmd;
    logic [IW-1:0]       frame_idx;
    logic                is_number;

    ddff_ctrl #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .is_number (is_number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .frame_idx (frame_idx)
    );

    ddff_datapath #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .in_data   (in_data),
        .cmd       (cmd),
        .frame_idx (frame_idx),
        .is_number (is_number),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/ddff_checker.sv =====
`include "display_digit_frame_formatter_defines.svh"

module ddff_checker #(
    parameter int NUM_DIGITS = 4
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ddff_pkg::out_word_t out_data
);

    `DDFF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data))

    `DDFF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    `DDFF_ASSERT_SAME(a_last_at_end, clk, rst_n, out_valid,
        out_data.last_frame == (out_data.frame_address == 3'(NUM_DIGITS)))

    `DDFF_ASSERT_NEXT(a_addr_step, clk, rst_n, out_valid && out_ready && !out_data.last_frame,
        out_valid && (out_data.frame_address == $past(out_data.frame_address) + 3'd1))

endmodule

bind display_digit_frame_formatter ddff_checker #(
    .NUM_DIGITS(NUM_DIGITS)
) u_ddff_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam string GLYPHS = "0123456789-EeHhLlPp";

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ddff_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ddff_pkg::out_word_t out_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    class frame_scoreboard;
        ddff_pkg::out_word_t expected_frames[$];
        int unsigned errors;
        int unsigned frames_checked;
        int unsigned cmd_seen[4];

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        function logic [3:0] glyph_code(logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return c[3:0];
            end
            case (c)
                "-":      return ddff_pkg::CODE_MINUS;
                "E", "e": return ddff_pkg::CODE_E;
                "H", "h": return ddff_pkg::CODE_H;
                "L", "l": return ddff_pkg::CODE_L;
                "P", "p": return ddff_pkg::CODE_P;
                default:  return ddff_pkg::CODE_BLANK;
            endcase
        endfunction

        function void note_request(ddff_pkg::in_word_t w);
            logic [3:0] codes [DIGITS];
            logic [7:0] elems [ddff_pkg::ELEM_COUNT];
            int unsigned value;
            int unsigned pos;
            int unsigned count;
            int unsigned lim;
            ddff_pkg::out_word_t f;
            elems = '{w.elem_a, w.elem_b, w.elem_c, w.elem_d};
            lim = (DIGITS < ddff_pkg::ELEM_COUNT) ? DIGITS : ddff_pkg::ELEM_COUNT;
            foreach (codes[i])
            begin
                codes[i] = ddff_pkg::CODE_BLANK;
            end
            cmd_seen[w.cmd]++;
            case (w.cmd)
                ddff_pkg::CMD_NUMBER:
                begin
                    value = w.number;
                    pos = DIGITS;
                    if (value == 0)
                    begin
                        codes[DIGITS - 1] = 4'd0;
                    end
                    while (value > 0 && pos > 0)
                    begin
                        pos--;
                        codes[pos] = 4'(value % 10);
                        value = value / 10;
                    end
                end
                ddff_pkg::CMD_CHARS, ddff_pkg::CMD_RAW:
                begin
                    count = (w.char_count > lim) ? lim : w.char_count;
                    for (int i = 0; i < count; i++)
                    begin
                        codes[DIGITS - count + i] = (w.cmd == ddff_pkg::CMD_CHARS) ?
                            glyph_code(elems[i]) : elems[i][3:0];
                    end
                end
                default:
                begin
                end
            endcase
            for (int i = 0; i < DIGITS; i++)
            begin
                f.frame_address = ddff_pkg::ADDR_BASE + 3'(i);
                f.frame_data = codes[i];
                f.last_frame = (i == DIGITS - 1);
                expected_frames.push_back(f);
            end
        endfunction

        task check_frame(ddff_pkg::out_word_t got);
            ddff_pkg::out_word_t want;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected frame addr %0d data %0h",
                    got.frame_address, got.frame_data));
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (got.frame_address !== want.frame_address)
            begin
                report($sformatf("frame %0d address %0d, expected %0d",
                    frames_checked, got.frame_address, want.frame_address));
            end
            if (got.frame_data !== want.frame_data)
            begin
                report($sformatf("frame %0d data %0h, expected %0h",
                    frames_checked, got.frame_data, want.frame_data));
            end
            if (got.last_frame !== want.last_frame)
            begin
                report($sformatf("frame %0d last flag %0b, expected %0b",
                    frames_checked, got.last_frame, want.last_frame));
            end
        endtask
    endclass

    frame_scoreboard sb = new();

    display_digit_frame_formatter #(
        .NUM_DIGITS(DIGITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The sink pacing lives here so a long hold-off can run while the source keeps offering.
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_frame(out_data);
        end
    end

    function automatic ddff_pkg::in_word_t make_request(logic [1:0] cmd, logic [15:0] number,
        logic [2:0] count, logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
        ddff_pkg::in_word_t w;
        w.cmd = cmd;
        w.number = number;
        w.char_count = count;
        w.elem_a = a;
        w.elem_b = b;
        w.elem_c = c;
        w.elem_d = d;
        return w;
    endfunction

    function automatic logic [7:0] random_elem(logic [1:0] cmd);
        if (cmd == ddff_pkg::CMD_CHARS && $urandom_range(3) != 0)
        begin
            return GLYPHS[$urandom_range(GLYPHS.len() - 1)];
        end
        return 8'($urandom);
    endfunction

    function automatic ddff_pkg::in_word_t random_request();
        ddff_pkg::in_word_t w;
        w.cmd = 2'($urandom_range(3));
        case ($urandom_range(3))
            0: w.number = 16'($urandom_range(9));
            1: w.number = 16'($urandom_range(9999));
            2: w.number = 16'($urandom);
            default: w.number = 16'($urandom_range(65535, 10000));
        endcase
        w.char_count = 3'($urandom_range(7));
        w.elem_a = random_elem(w.cmd);
        w.elem_b = random_elem(w.cmd);
        w.elem_c = random_elem(w.cmd);
        w.elem_d = random_elem(w.cmd);
        return w;
    endfunction

    task offer_request(ddff_pkg::in_word_t w);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(w);
    endtask

    task run_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
        begin
            offer_request(random_request());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd0, 3'd4,
            8'h00, 8'h00, 8'h00, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd7, 3'd0,
            8'hFF, 8'hFF, 8'hFF, 8'hFF));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd120, 3'd0,
            8'h00, 8'h00, 8'h00, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd9999, 3'd0,
            8'h00, 8'h00, 8'h00, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd10000, 3'd0,
            8'h00, 8'h00, 8'h00, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'd10005, 3'd0,
            8'h00, 8'h00, 8'h00, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_NUMBER, 16'hFFFF, 3'd7,
            8'hFF, 8'hFF, 8'hFF, 8'hFF));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd4, "-", "E", "H", "L"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd4, "e", "h", "l", "p"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd4, "P", "0", "9", "/"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd7, ":", 8'h00, 8'hFF, "h"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd0, "E", "E", "E", "E"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd2, "1", "2", "3", "4"));
        offer_request(make_request(ddff_pkg::CMD_CHARS, 16'd0, 3'd3, "l", "p", "5", "E"));
        offer_request(make_request(ddff_pkg::CMD_RAW, 16'd0, 3'd4,
            8'hFF, 8'h0A, 8'h35, 8'h00));
        offer_request(make_request(ddff_pkg::CMD_RAW, 16'd0, 3'd7,
            8'h12, 8'h34, 8'h56, 8'h78));
        offer_request(make_request(ddff_pkg::CMD_RAW, 16'd0, 3'd0,
            8'h09, 8'h09, 8'h09, 8'h09));
        offer_request(make_request(ddff_pkg::CMD_RAW, 16'd0, 3'd1,
            8'hA9, 8'h01, 8'h02, 8'h03));
        offer_request(make_request(ddff_pkg::CMD_BLANK, 16'hFFFF, 3'd7,
            8'hFF, 8'hFF, 8'hFF, 8'hFF));
        offer_request(make_request(ddff_pkg::CMD_BLANK, 16'd0, 3'd0,
            8'h00, 8'h00, 8'h00, 8'h00));

        run_phase(0, 0, 90);

        // The sink stops for a long stretch while requests keep coming, so the block backs up.
        hold_requests++;
        run_phase(0, 0, 16);

        run_phase(85, 0, 115);
        run_phase(0, 85, 115);
        run_phase(34, 34, 115);

        in_valid <= 1'b0;
        while (sb.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d number, %0d character, %0d raw and %0d blank requests; %0d frames.",
            sb.cmd_seen[ddff_pkg::CMD_NUMBER], sb.cmd_seen[ddff_pkg::CMD_CHARS],
            sb.cmd_seen[ddff_pkg::CMD_RAW], sb.cmd_seen[ddff_pkg::CMD_BLANK],
            sb.frames_checked);
        $display("Pacing ran free, with a held-off sink, a sparse source, a stalled sink and both.");
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d frames still due.", sb.expected_frames.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ddff_pkg.sv
hw/rtl/ddff_ctrl.sv
hw/rtl/ddff_datapath.sv
hw/rtl/display_digit_frame_formatter.sv
hw/rtl/ddff_checker.sv
verif/testbench.sv
